>>> rtl/uart_rx_tx_ring_buffer_macros.svh
// Assertion macros for the UART ring buffer block.
`ifndef UART_RX_TX_RING_BUFFER_MACROS_SVH
`define UART_RX_TX_RING_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define URB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define URB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define URB_ASSERT(lbl, prop, msg)
`define URB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/urb_pkg.sv
// Types and constants shared by the UART ring buffer modules.
`default_nettype none
package urb_pkg;

  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_FW = RX_AW + 1;
  localparam int TX_FW = TX_AW + 1;
  localparam logic [RX_FW-1:0] RX_FILL_MAX = RX_FW'(RX_DEPTH);
  localparam logic [TX_FW-1:0] TX_FILL_MAX = TX_FW'(TX_DEPTH);
  localparam logic [RX_AW-1:0] RX_PTR_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_PTR_LAST = TX_AW'(TX_DEPTH - 1);

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] MAX_BURST = CFG_W'(16);
  localparam logic [CFG_W-1:0] BURST_RESET = CFG_W'(16);

  localparam logic [2:0] MODE_RX_BYTE = 3'd0;
  localparam logic [2:0] MODE_LINE_STATUS = 3'd1;
  localparam logic [2:0] MODE_POP = 3'd2;
  localparam logic [2:0] MODE_PUSH = 3'd3;
  localparam logic [2:0] MODE_TX_ROOM = 3'd4;
  localparam logic [2:0] MODE_SET_WAIT = 3'd5;

  localparam logic [3:0] ERR_OVERRUN = 4'b0001;
  localparam logic [3:0] ERR_BREAK = 4'b1000;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_BREAK = 2'd1;
  localparam logic [1:0] STAT_OVERRUN = 2'd2;
  localparam logic [1:0] STAT_OTHER = 2'd3;

  typedef enum logic [2:0] {
    CMD_RX_BYTE,
    CMD_LINE_STATUS,
    CMD_POP,
    CMD_PUSH,
    CMD_TX_ROOM,
    CMD_SET_WAIT,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data_byte;
    logic [3:0]  line_errors;
    logic [15:0] wait_bytes;
    logic        read_last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       push_accepted;
    logic [1:0] read_status;
    logic       status_valid;
    logic       wake_reader;
    logic       tx_done;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/urb_front.sv
// Front end: accepts items, classifies the mode and queues commands.
`default_nettype none
module urb_front import urb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [3:0]  line_errors_i,
  input  wire logic [15:0] wait_bytes_i,
  input  wire logic        read_last_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.data_byte   = data_byte_i;
    cmd_in.line_errors = line_errors_i;
    cmd_in.wait_bytes  = wait_bytes_i;
    cmd_in.read_last   = read_last_i;
    case (mode_i)
      MODE_RX_BYTE:     cmd_in.kind = CMD_RX_BYTE;
      MODE_LINE_STATUS: cmd_in.kind = CMD_LINE_STATUS;
      MODE_POP:         cmd_in.kind = CMD_POP;
      MODE_PUSH:        cmd_in.kind = CMD_PUSH;
      MODE_TX_ROOM:     cmd_in.kind = CMD_TX_ROOM;
      MODE_SET_WAIT:    cmd_in.kind = CMD_SET_WAIT;
      default:          cmd_in.kind = CMD_NOP;
    endcase
  end

  assign s_ready_o   = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/urb_back.sv
// Back end: ring memories, sticky status, wait counter and result register.
`default_nettype none
`include "uart_rx_tx_ring_buffer_macros.svh"
module urb_back import urb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire cmd_t             cmd_i,
  input  wire logic [CFG_W-1:0] burst_limit_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output res_t                  res_o
);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_TX} state_e;

  state_e           state_q, state_d;
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_rdata_q, tx_rdata_q;
  logic [RX_AW-1:0] rx_wr_ptr_q, rx_wr_ptr_d, rx_rd_ptr_q, rx_rd_ptr_d;
  logic [TX_AW-1:0] tx_wr_ptr_q, tx_wr_ptr_d, tx_rd_ptr_q, tx_rd_ptr_d;
  logic [RX_FW-1:0] rx_fill_q, rx_fill_d;
  logic [TX_FW-1:0] tx_fill_q, tx_fill_d;
  logic [3:0]       sticky_q, sticky_d;
  logic [15:0]      wait_q, wait_d;
  logic             rlast_q, rlast_d;
  logic [CFG_W-1:0] cnt_q, cnt_d, lim_q, lim_d, limit;
  logic             m_valid_q, m_valid_d;
  res_t             res_q, res_d, res_new;
  logic             emit, out_free, fin;
  logic             rx_we, rx_re, tx_we, tx_re;

  function automatic logic [1:0] status_code(logic [3:0] s);
    if (s == 4'd0) begin
      return STAT_OK;
    end else if ((s & ERR_BREAK) != 4'd0) begin
      return STAT_BREAK;
    end else if ((s & ERR_OVERRUN) != 4'd0) begin
      return STAT_OVERRUN;
    end
    return STAT_OTHER;
  endfunction

  assign out_free    = !m_valid_q || m_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign limit       = (burst_limit_i > MAX_BURST) ? MAX_BURST : burst_limit_i;
  assign fin         = (cnt_q == lim_q) || (tx_fill_q == '0);
  assign m_valid_o   = m_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    rx_wr_ptr_d = rx_wr_ptr_q;
    rx_rd_ptr_d = rx_rd_ptr_q;
    tx_wr_ptr_d = tx_wr_ptr_q;
    tx_rd_ptr_d = tx_rd_ptr_q;
    rx_fill_d   = rx_fill_q;
    tx_fill_d   = tx_fill_q;
    sticky_d    = sticky_q;
    wait_d      = wait_q;
    rlast_d     = rlast_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    emit        = 1'b0;
    res_new     = '0;
    res_new.last = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          case (cmd_i.kind)
            CMD_RX_BYTE: begin
              emit = 1'b1;
              if (rx_fill_q < RX_FILL_MAX) begin
                rx_we       = 1'b1;
                rx_wr_ptr_d = (rx_wr_ptr_q == RX_PTR_LAST) ? '0 : rx_wr_ptr_q + 1'b1;
                rx_fill_d   = rx_fill_q + 1'b1;
              end else begin
                sticky_d = sticky_q | ERR_OVERRUN;
              end
              if (cmd_i.line_errors != 4'd0) begin
                sticky_d = cmd_i.line_errors;
              end
              if (wait_q <= 16'd1) begin
                wait_d              = '0;
                res_new.wake_reader = 1'b1;
              end else begin
                wait_d = wait_q - 1'b1;
              end
            end
            CMD_LINE_STATUS: begin
              emit = 1'b1;
              if (cmd_i.line_errors != 4'd0) begin
                sticky_d = cmd_i.line_errors;
              end
            end
            CMD_POP: begin
              if (rx_fill_q != '0) begin
                rx_re       = 1'b1;
                rx_rd_ptr_d = (rx_rd_ptr_q == RX_PTR_LAST) ? '0 : rx_rd_ptr_q + 1'b1;
                rx_fill_d   = rx_fill_q - 1'b1;
                rlast_d     = cmd_i.read_last;
                state_d     = S_POP;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_PUSH: begin
              emit = 1'b1;
              if (tx_fill_q < TX_FILL_MAX) begin
                tx_we                 = 1'b1;
                tx_wr_ptr_d           = (tx_wr_ptr_q == TX_PTR_LAST) ? '0 : tx_wr_ptr_q + 1'b1;
                tx_fill_d             = tx_fill_q + 1'b1;
                res_new.push_accepted = 1'b1;
              end
            end
            CMD_TX_ROOM: begin
              if ((limit != '0) && (tx_fill_q != '0)) begin
                tx_re       = 1'b1;
                tx_rd_ptr_d = (tx_rd_ptr_q == TX_PTR_LAST) ? '0 : tx_rd_ptr_q + 1'b1;
                tx_fill_d   = tx_fill_q - 1'b1;
                cnt_d       = CFG_W'(1);
                lim_d       = limit;
                state_d     = S_TX;
              end else begin
                emit            = 1'b1;
                res_new.tx_done = (tx_fill_q == '0);
              end
            end
            CMD_SET_WAIT: begin
              emit   = 1'b1;
              wait_d = cmd_i.wait_bytes;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          emit               = 1'b1;
          res_new.out_byte   = rx_rdata_q;
          res_new.byte_valid = 1'b1;
          if (rlast_q) begin
            res_new.read_status  = status_code(sticky_q);
            res_new.status_valid = 1'b1;
            sticky_d             = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_TX: begin
        if (out_free) begin
          emit               = 1'b1;
          res_new.out_byte   = tx_rdata_q;
          res_new.byte_valid = 1'b1;
          res_new.last       = fin;
          res_new.tx_done    = fin && (tx_fill_q == '0);
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            tx_re       = 1'b1;
            tx_rd_ptr_d = (tx_rd_ptr_q == TX_PTR_LAST) ? '0 : tx_rd_ptr_q + 1'b1;
            tx_fill_d   = tx_fill_q - 1'b1;
            cnt_d       = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    m_valid_d = emit || (m_valid_q && !m_ready_i);
    res_d     = emit ? res_new : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rx_wr_ptr_q <= '0;
      rx_rd_ptr_q <= '0;
      tx_wr_ptr_q <= '0;
      tx_rd_ptr_q <= '0;
      rx_fill_q   <= '0;
      tx_fill_q   <= '0;
      sticky_q    <= '0;
      wait_q      <= '0;
      rlast_q     <= 1'b0;
      cnt_q       <= '0;
      lim_q       <= '0;
      m_valid_q   <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      rx_wr_ptr_q <= rx_wr_ptr_d;
      rx_rd_ptr_q <= rx_rd_ptr_d;
      tx_wr_ptr_q <= tx_wr_ptr_d;
      tx_rd_ptr_q <= tx_rd_ptr_d;
      rx_fill_q   <= rx_fill_d;
      tx_fill_q   <= tx_fill_d;
      sticky_q    <= sticky_d;
      wait_q      <= wait_d;
      rlast_q     <= rlast_d;
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      m_valid_q   <= m_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wr_ptr_q] <= cmd_i.data_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wr_ptr_q] <= cmd_i.data_byte;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_rd_ptr_q];
    end
  end

  `URB_ASSERT(a_rx_fill_max, rx_fill_q <= RX_FILL_MAX, "rx fill beyond depth")
  `URB_ASSERT(a_rx_empty_ptrs, (rx_fill_q == '0) |-> (rx_wr_ptr_q == rx_rd_ptr_q), "rx ptrs")
  `URB_ASSERT(a_tx_empty_ptrs, (tx_fill_q == '0) |-> (tx_wr_ptr_q == tx_rd_ptr_q), "tx ptrs")
  `URB_ASSERT(a_status_byte, (m_valid_q && res_q.status_valid) |-> res_q.byte_valid, "status")
  `URB_ASSERT(a_burst_bound, (state_q == S_TX) |-> ((cnt_q <= lim_q) && (lim_q <= MAX_BURST)), "burst")
  `URB_ASSERT_NEXT(a_pop_read, (cmd_valid_i && cmd_ready_o && (cmd_i.kind == CMD_POP) && (rx_fill_q != '0)), (state_q == S_POP), "pop")

endmodule
`default_nettype wire

>>> rtl/uart_rx_tx_ring_buffer.sv
// UART receive/transmit ring buffer: top level with stream ports and burst register.
// Items pass the front queue and the result register; a pop or sending transmit-room item
// also passes a ring read register. Throughput: one item per cycle while the output is free,
// except a pop that returns a byte or a transmit-room item that sends (at most 16 bytes).
// The back end has a single read port on each ring memory and one result register.
// Reset (rst_ni, async, active low) empties both rings and clears status and wait count.
`default_nettype none
module uart_rx_tx_ring_buffer import urb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [31:0]      s_axis_tdata,   // data_byte, line_errors, wait_bytes, pad
  input  wire logic [2:0]       s_axis_tuser,   // mode
  input  wire logic             s_axis_tlast,   // read_last
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // out_byte, push_accepted, read_status,
                                                // status_valid, wake_reader, tx_done, pad
  output logic                  m_axis_tuser,   // byte_valid
  output logic                  m_axis_tlast,   // last
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  res_t             res;
  logic [CFG_W-1:0] burst_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_limit_q <= BURST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      burst_limit_q <= cfg_data_i;
    end
  end

  urb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .mode_i        (s_axis_tuser),
    .data_byte_i   (s_axis_tdata[7:0]),
    .line_errors_i (s_axis_tdata[11:8]),
    .wait_bytes_i  (s_axis_tdata[27:12]),
    .read_last_i   (s_axis_tlast),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  urb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .burst_limit_i (burst_limit_q),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {2'b00, res.tx_done, res.wake_reader, res.status_valid,
                         res.read_status, res.push_accepted, res.out_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

>>> tb/sv/uart_rx_tx_ring_buffer_tb.sv
// Self-checking stream testbench for the UART ring buffer: directed table, then random traffic and an overflow phase.
`timescale 1ns / 1ps
module uart_rx_tx_ring_buffer_tb;
  import urb_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data;
    logic [3:0]  errs;
    logic [15:0] wait_b;
    logic        rlast;
  } buf_cmd_t;

  typedef struct {
    buf_cmd_t c;
    bit       typed;
    res_t     want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic [2:0]       s_axis_tuser = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  // predictor state
  logic [7:0]       rx_ring [RX_DEPTH];
  logic [7:0]       tx_ring [TX_DEPTH];
  logic [RX_AW-1:0] rx_rd, rx_wr;
  logic [TX_AW-1:0] tx_rd, tx_wr;
  int               rx_cnt, tx_cnt;
  logic [3:0]       err_sticky;
  logic [15:0]      wait_cnt;
  logic [CFG_W-1:0] burst_cfg;

  res_t             results_due [$];
  dir_row_t         dir_rows [$];
  int               items_offered = 0;
  int               fail_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_target = 0;
  int               hold_count = 0;
  res_t             mon_got, mon_want;

  uart_rx_tx_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic buf_cmd_t cmd(input logic [2:0] mode, input logic [7:0] data,
                                   input logic [3:0] errs, input logic [15:0] wait_b,
                                   input logic rlast);
    buf_cmd_t c;
    c.mode = mode;
    c.data = data;
    c.errs = errs;
    c.wait_b = wait_b;
    c.rlast = rlast;
    return c;
  endfunction

  function automatic res_t resp(input logic [7:0] b, input logic valid, input logic acc,
                                input logic [1:0] st, input logic stv, input logic wake,
                                input logic done, input logic lst);
    res_t r;
    r.out_byte = b;
    r.byte_valid = valid;
    r.push_accepted = acc;
    r.read_status = st;
    r.status_valid = stv;
    r.wake_reader = wake;
    r.tx_done = done;
    r.last = lst;
    return r;
  endfunction

  function automatic string res_str(input res_t r);
    return $sformatf("byte=%h bv=%0b acc=%0b st=%0d stv=%0b wake=%0b done=%0b last=%0b",
                     r.out_byte, r.byte_valid, r.push_accepted, r.read_status,
                     r.status_valid, r.wake_reader, r.tx_done, r.last);
  endfunction

  function automatic logic [3:0] rand_errs();
    return ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0;
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic void buffer_step(input buf_cmd_t c);
    res_t r, b;
    int lim, n;
    r = '0;
    r.last = 1'b1;
    case (c.mode)
      MODE_RX_BYTE: begin
        if (rx_cnt < RX_DEPTH) begin
          rx_ring[rx_wr] = c.data;
          rx_wr = (rx_wr == RX_PTR_LAST) ? '0 : rx_wr + 1'b1;
          rx_cnt++;
        end else begin
          err_sticky = err_sticky | ERR_OVERRUN;
        end
        if (c.errs != 4'h0) err_sticky = c.errs;
        if (wait_cnt <= 16'd1) begin
          wait_cnt = '0;
          r.wake_reader = 1'b1;
        end else begin
          wait_cnt = wait_cnt - 16'd1;
        end
      end
      MODE_LINE_STATUS: begin
        if (c.errs != 4'h0) err_sticky = c.errs;
      end
      MODE_POP: begin
        if (rx_cnt > 0) begin
          r.out_byte = rx_ring[rx_rd];
          r.byte_valid = 1'b1;
          rx_rd = (rx_rd == RX_PTR_LAST) ? '0 : rx_rd + 1'b1;
          rx_cnt--;
          if (c.rlast) begin
            if (err_sticky == 4'h0) r.read_status = STAT_OK;
            else if ((err_sticky & ERR_BREAK) != 4'h0) r.read_status = STAT_BREAK;
            else if ((err_sticky & ERR_OVERRUN) != 4'h0) r.read_status = STAT_OVERRUN;
            else r.read_status = STAT_OTHER;
            r.status_valid = 1'b1;
            err_sticky = 4'h0;
          end
        end
      end
      MODE_PUSH: begin
        if (tx_cnt < TX_DEPTH) begin
          tx_ring[tx_wr] = c.data;
          tx_wr = (tx_wr == TX_PTR_LAST) ? '0 : tx_wr + 1'b1;
          tx_cnt++;
          r.push_accepted = 1'b1;
        end
      end
      MODE_TX_ROOM: begin
        lim = (burst_cfg > MAX_BURST) ? int'(MAX_BURST) : int'(burst_cfg);
        n = 0;
        while (n < lim && tx_cnt > 0) begin
          b = '0;
          b.out_byte = tx_ring[tx_rd];
          b.byte_valid = 1'b1;
          tx_rd = (tx_rd == TX_PTR_LAST) ? '0 : tx_rd + 1'b1;
          tx_cnt--;
          n++;
          if (n == lim || tx_cnt == 0) begin
            b.last = 1'b1;
            b.tx_done = (tx_cnt == 0);
          end
          results_due.push_back(b);
        end
        r.tx_done = (tx_cnt == 0);
        if (n != 0) return;
      end
      MODE_SET_WAIT: wait_cnt = c.wait_b;
      default: ;
    endcase
    results_due.push_back(r);
  endfunction

  // Offers one item; on acceptance the expectations are queued, a typed one replacing
  // the single predicted result.
  task automatic offer_item(input buf_cmd_t c, input bit typed, input res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, c.wait_b, c.errs, c.data};
    s_axis_tuser <= c.mode;
    s_axis_tlast <= c.rlast;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    buffer_step(c);
    if (typed) begin
      void'(results_due.pop_back());
      results_due.push_back(want);
    end
    items_offered++;
  endtask

  task automatic offer(input buf_cmd_t c);
    offer_item(c, 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_burst_limit(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    burst_cfg = v;
  endtask

  task automatic add_row(input buf_cmd_t c, input bit typed, input res_t want);
    dir_row_t row;
    row.c = c;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed read and write exchanges, with some noise items between.
  task automatic random_phase(input int n);
    int start, k, pick;
    start = items_offered;
    while (items_offered - start < n) begin
      pick = $urandom_range(99);
      k = $urandom_range(1, 6);
      if (pick < 35) begin
        offer(cmd(MODE_SET_WAIT, 8'($urandom), 4'($urandom),
                  16'(k + $urandom_range(0, 2) - 1), 1'($urandom_range(1))));
        for (int i = 0; i < k; i++)
          offer(cmd(MODE_RX_BYTE, 8'($urandom), rand_errs(), 16'($urandom),
                    1'($urandom_range(1))));
        for (int i = 0; i < k; i++)
          offer(cmd(MODE_POP, 8'($urandom), 4'($urandom), 16'($urandom),
                    (i == k - 1) || ($urandom_range(9) == 0)));
      end else if (pick < 65) begin
        for (int i = 0; i < k; i++)
          offer(cmd(MODE_PUSH, 8'($urandom), 4'($urandom), 16'($urandom),
                    1'($urandom_range(1))));
        offer(cmd(MODE_TX_ROOM, 8'($urandom), 4'($urandom), 16'($urandom),
                  1'($urandom_range(1))));
      end else begin
        offer(cmd(3'($urandom_range(7)), 8'($urandom),
                  ($urandom_range(1) == 0) ? 4'h0 : 4'($urandom), 16'($urandom),
                  1'($urandom_range(1))));
      end
    end
  endtask

  // Receiver holds off while the receive ring is overfilled, so the block backs up.
  task automatic overflow_phase();
    hold_target <= hold_count + 400;
    for (int i = 0; i < RX_DEPTH + 4; i++)
      offer(cmd(MODE_RX_BYTE, 8'($urandom), (i >= RX_DEPTH) ? rand_errs() : 4'h0,
                16'($urandom), 1'($urandom_range(1))));
    wait_drained();
    for (int i = 0; i < 12; i++)
      offer(cmd(MODE_POP, 8'($urandom), 4'($urandom), 16'($urandom), i == 11));
    repeat (3) offer(cmd(MODE_TX_ROOM, 8'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom_range(1))));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_count <= 0;
    end else if (hold_count < hold_target) begin
      hold_count <= hold_count + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.out_byte = m_axis_tdata[7:0];
      mon_got.push_accepted = m_axis_tdata[8];
      mon_got.read_status = m_axis_tdata[10:9];
      mon_got.status_valid = m_axis_tdata[11];
      mon_got.wake_reader = m_axis_tdata[12];
      mon_got.tx_done = m_axis_tdata[13];
      mon_got.byte_valid = m_axis_tuser;
      mon_got.last = m_axis_tlast;
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: %s", res_str(mon_got));
      end else begin
        mon_want = results_due.pop_front();
        if (mon_got.out_byte !== mon_want.out_byte ||
            mon_got.byte_valid !== mon_want.byte_valid ||
            mon_got.push_accepted !== mon_want.push_accepted ||
            mon_got.read_status !== mon_want.read_status ||
            mon_got.status_valid !== mon_want.status_valid ||
            mon_got.wake_reader !== mon_want.wake_reader ||
            mon_got.tx_done !== mon_want.tx_done ||
            mon_got.last !== mon_want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                     res_str(mon_want), res_str(mon_got));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rx_rd = '0;
    rx_wr = '0;
    rx_cnt = 0;
    tx_rd = '0;
    tx_wr = '0;
    tx_cnt = 0;
    err_sticky = 4'h0;
    wait_cnt = '0;
    burst_cfg = BURST_RESET;

    add_row(cmd(MODE_POP, 8'hFF, 4'hF, 16'hFFFF, 1'b1), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_TX_ROOM, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b1, 1'b1));
    add_row(cmd(MODE_RX_BYTE, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b1, 1'b0, 1'b1));
    add_row(cmd(MODE_SET_WAIT, 8'h00, 4'h0, 16'hFFFF, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_RX_BYTE, 8'hFF, 4'hF, 16'h0000, 1'b1), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_LINE_STATUS, 8'h00, 4'h4, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_LINE_STATUS, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_SET_WAIT, 8'h00, 4'h0, 16'h0002, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_RX_BYTE, 8'hA5, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_RX_BYTE, 8'h5A, 4'h2, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b1, 1'b0, 1'b1));
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b0, '0);
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b1), 1'b0, '0);
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b1), 1'b0, '0);
    add_row(cmd(MODE_LINE_STATUS, 8'h00, 4'h9, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b1), 1'b0, '0);
    add_row(cmd(MODE_LINE_STATUS, 8'h00, 4'h1, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    // empty pop with read_last keeps the sticky overrun
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b1), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_RX_BYTE, 8'h11, 4'h0, 16'h0000, 1'b0), 1'b0, '0);
    add_row(cmd(MODE_POP, 8'h00, 4'h0, 16'h0000, 1'b1), 1'b0, '0);
    add_row(cmd(MODE_PUSH, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b1, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_PUSH, 8'hFF, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b1, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_PUSH, 8'h3C, 4'h0, 16'h0000, 1'b0), 1'b1,
            resp(8'h00, 1'b0, 1'b1, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_TX_ROOM, 8'h00, 4'h0, 16'h0000, 1'b0), 1'b0, '0);
    add_row(cmd(MODE_SPARE_LO, 8'hFF, 4'hF, 16'hFFFF, 1'b1), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));
    add_row(cmd(MODE_SPARE_HI, 8'hFF, 4'hF, 16'hFFFF, 1'b1), 1'b1,
            resp(8'h00, 1'b0, 1'b0, STAT_OK, 1'b0, 1'b0, 1'b0, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_idle_pct = 20;
    recv_idle_pct = 48;
    foreach (dir_rows[i]) offer_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

    write_burst_limit(CFG_W'(31));
    random_phase(35);

    send_idle_pct = 48;
    recv_idle_pct = 20;
    write_burst_limit(CFG_W'(0));
    random_phase(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_burst_limit(CFG_W'(1));
    random_phase(35);

    write_burst_limit(CFG_W'(16));
    overflow_phase();

    write_burst_limit(CFG_W'($urandom_range(2, 15)));
    random_phase(30);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
